[rtl/dcedm_pkg.sv]
// Shared types, codes and constants for the dual channel edge delay matcher.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package dcedm_pkg;

  localparam int CAPTURE_WIDTH_DEF = 32;

  localparam logic [1:0] KIND_EDGE     = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [1:0] KIND_STATS    = 2'd3;

  localparam logic CFG_MAX_DELAY = 1'b0;
  localparam logic CFG_MAX_AGE   = 1'b1;

  localparam logic [30:0] MAX_DELAY_RESET = 31'd1000;
  localparam logic [61:0] MAX_AGE_RESET   = 62'd100000000;

  localparam logic [62:0] SQ_MAX = '1;

  typedef struct packed {
    logic [1:0]  kind;
    logic        channel;
    logic [31:0] capture_value;
    logic [62:0] now_ticks;
    logic        clear_stats;
  } in_item_t;

  typedef struct packed {
    logic               matched;
    logic [31:0]        pair_ts_a;
    logic [31:0]        pair_ts_b;
    logic signed [31:0] pair_delay;
    logic [31:0]        match_count;
    logic [31:0]        missed_count_a;
    logic [31:0]        missed_count_b;
    logic signed [31:0] delay_least;
    logic signed [31:0] delay_greatest;
    logic signed [63:0] delay_total;
    logic [62:0]        delay_square_total;
  } out_item_t;

  // Item after widening, as held in the queue between front and back.
  typedef struct packed {
    logic [1:0]  kind;
    logic        channel;
    logic [63:0] wide;
    logic [31:0] raw;
    logic [62:0] now;
    logic        clr;
  } wide_item_t;

  // Outcome of the pairing logic, carried to the statistics stage.
  typedef struct packed {
    logic [1:0]         kind;
    logic               matched;
    logic [31:0]        raw_a;
    logic [31:0]        raw_b;
    logic signed [31:0] d;
    logic               miss_a;
    logic               miss_b;
    logic               clr;
    logic [61:0]        sq;
  } event_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
    sat_inc = (en && (v != '1)) ? v + 32'd1 : v;
  endfunction

endpackage

[rtl/dcedm_front.sv]
// Front end: accepts input beats and widens edge captures with per-channel wrap counts.
// Depends on dcedm_pkg.
`timescale 1ns / 1ps

module dcedm_front #(
  parameter int CAPTURE_WIDTH = dcedm_pkg::CAPTURE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dcedm_pkg::in_item_t    in_item,
  output logic                   push_valid,
  input  logic                   push_ready,
  output dcedm_pkg::wide_item_t  push_item
);

  localparam logic [31:0] CAP_HALF = 32'(64'd1 << (CAPTURE_WIDTH - 1));

  logic [31:0] previous_raw_a, previous_raw_b;
  logic [31:0] wrap_count_a, wrap_count_b;
  logic [31:0] value, last, wrap, wrap_next;
  logic        wrap_hit, accept;

  assign value = 32'(in_item.capture_value[CAPTURE_WIDTH-1:0]);
  assign last  = in_item.channel ? previous_raw_b : previous_raw_a;
  assign wrap  = in_item.channel ? wrap_count_b : wrap_count_a;

  // A drop of more than half the capture range means the timer wrapped.
  assign wrap_hit  = (last != 32'd0) && (value < last) && ((last - value) > CAP_HALF);
  assign wrap_next = wrap + {31'd0, wrap_hit};

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_item.kind    = in_item.kind;
    push_item.channel = in_item.channel;
    push_item.wide    = ({32'd0, wrap_next} << CAPTURE_WIDTH) | {32'd0, value};
    push_item.raw     = value;
    push_item.now     = in_item.now_ticks;
    push_item.clr     = in_item.clear_stats;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw_a <= '0;
      previous_raw_b <= '0;
      wrap_count_a   <= '0;
      wrap_count_b   <= '0;
    end else if (accept) begin
      if (in_item.kind == dcedm_pkg::KIND_EDGE) begin
        if (in_item.channel) begin
          previous_raw_b <= value;
          wrap_count_b   <= wrap_next;
        end else begin
          previous_raw_a <= value;
          wrap_count_a   <= wrap_next;
        end
      end else if (in_item.kind == dcedm_pkg::KIND_OVERFLOW) begin
        wrap_count_a <= wrap_count_a + 32'd1;
        wrap_count_b <= wrap_count_b + 32'd1;
      end
    end
  end

endmodule

[rtl/dcedm_queue.sv]
// Two-entry queue of widened items between the front end and the back end.
// Depends on dcedm_pkg.
`timescale 1ns / 1ps

module dcedm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  dcedm_pkg::wide_item_t push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output dcedm_pkg::wide_item_t pop_item
);

  dcedm_pkg::wide_item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/dcedm_back.sv]
// Back end: pending-edge pairing, squaring stage, statistics and the output register.
// Depends on dcedm_pkg; holds the configuration registers.
`timescale 1ns / 1ps

module dcedm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  dcedm_pkg::wide_item_t pop_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [63:0]           cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dcedm_pkg::out_item_t  out_item
);

  logic [30:0] max_delay_ticks;
  logic [61:0] age_limit_ticks;

  logic        pending_valid_a, pending_valid_b;
  logic [63:0] pending_wide_a, pending_wide_b;
  logic [31:0] pending_raw_a, pending_raw_b;
  logic        pending_valid_a_next, pending_valid_b_next;
  logic [63:0] pending_wide_a_next, pending_wide_b_next;
  logic [31:0] pending_raw_a_next, pending_raw_b_next;

  logic                p_valid, q_valid;
  dcedm_pkg::event_t   p_ev, q_ev, ev, p_ev_sq;

  logic [31:0]        match_tally, miss_tally_a, miss_tally_b;
  logic signed [31:0] least_delay, greatest_delay;
  logic signed [63:0] sum_of_delays;
  logic [62:0]        sum_of_squares;

  logic [31:0]        match_tally_next, miss_tally_a_next, miss_tally_b_next;
  logic signed [31:0] least_delay_next, greatest_delay_next;
  logic signed [63:0] sum_of_delays_next;
  logic [62:0]        sum_of_squares_next;

  logic q_take, p_move, p_take, q_move, out_free, pop;
  logic [63:0] diff, age_a, age_b;
  logic        in_window;
  logic [31:0] mag;
  logic [64:0] sum_ext;
  logic [63:0] sq_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay_ticks <= dcedm_pkg::MAX_DELAY_RESET;
      age_limit_ticks <= dcedm_pkg::MAX_AGE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == dcedm_pkg::CFG_MAX_DELAY) max_delay_ticks <= cfg_data[30:0];
      else age_limit_ticks <= cfg_data[61:0];
    end
  end

  // Stage handshakes: each stage moves on when the one after it has room.
  assign out_free  = !out_valid || out_ready;
  assign q_move    = q_valid && out_free;
  assign q_take    = !q_valid || out_free;
  assign p_move    = p_valid && q_take;
  assign p_take    = !p_valid || p_move;
  assign pop_ready = p_take;
  assign pop       = pop_valid && p_take;

  // Pairing logic works on the item leaving the queue.
  always_comb begin
    pending_valid_a_next = pending_valid_a;
    pending_valid_b_next = pending_valid_b;
    pending_wide_a_next  = pending_wide_a;
    pending_wide_b_next  = pending_wide_b;
    pending_raw_a_next   = pending_raw_a;
    pending_raw_b_next   = pending_raw_b;
    if (pop_item.kind == dcedm_pkg::KIND_EDGE) begin
      if (pop_item.channel) begin
        pending_wide_b_next = pop_item.wide;
        pending_raw_b_next  = pop_item.raw;
      end else begin
        pending_wide_a_next = pop_item.wide;
        pending_raw_a_next  = pop_item.raw;
      end
    end
    diff = pending_wide_b_next - pending_wide_a_next;
    // |diff| <= M exactly when diff + M, taken modulo 2^64, is at most 2M.
    in_window = (diff + {33'd0, max_delay_ticks}) <= {32'd0, max_delay_ticks, 1'b0};
    age_a = {1'b0, pop_item.now} - pending_wide_a;
    age_b = {1'b0, pop_item.now} - pending_wide_b;

    ev      = '0;
    ev.kind = pop_item.kind;
    ev.clr  = pop_item.clr;
    case (pop_item.kind)
      dcedm_pkg::KIND_EDGE: begin
        if (pop_item.channel) begin
          ev.miss_b = pending_valid_b;
          pending_valid_b_next = 1'b1;
          if (pending_valid_a) begin
            if (in_window) begin
              ev.matched = 1'b1;
            end else if (pending_wide_a < pop_item.wide) begin
              ev.miss_a = 1'b1;
              pending_valid_a_next = 1'b0;
            end
          end
        end else begin
          ev.miss_a = pending_valid_a;
          pending_valid_a_next = 1'b1;
          if (pending_valid_b) begin
            if (in_window) begin
              ev.matched = 1'b1;
            end else if (pending_wide_b < pop_item.wide) begin
              ev.miss_b = 1'b1;
              pending_valid_b_next = 1'b0;
            end
          end
        end
        if (ev.matched) begin
          ev.raw_a = pending_raw_a_next;
          ev.raw_b = pending_raw_b_next;
          ev.d     = diff[31:0];
          pending_valid_a_next = 1'b0;
          pending_valid_b_next = 1'b0;
        end
      end
      dcedm_pkg::KIND_TIMEOUT: begin
        if (pending_valid_a && !age_a[63] && (age_a > {2'd0, age_limit_ticks})) begin
          ev.miss_a = 1'b1;
          pending_valid_a_next = 1'b0;
        end
        if (pending_valid_b && !age_b[63] && (age_b > {2'd0, age_limit_ticks})) begin
          ev.miss_b = 1'b1;
          pending_valid_b_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid_a <= 1'b0;
      pending_valid_b <= 1'b0;
      p_valid         <= 1'b0;
    end else begin
      if (pop) begin
        pending_valid_a <= pending_valid_a_next;
        pending_valid_b <= pending_valid_b_next;
      end
      if (p_take) p_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pending_wide_a <= pending_wide_a_next;
      pending_wide_b <= pending_wide_b_next;
      pending_raw_a  <= pending_raw_a_next;
      pending_raw_b  <= pending_raw_b_next;
      p_ev           <= ev;
    end
  end

  // Squaring stage; a matched delay never exceeds 2^31 - 1 in magnitude.
  assign mag = p_ev.d[31] ? 32'(-p_ev.d) : 32'(p_ev.d);

  always_comb begin
    p_ev_sq    = p_ev;
    p_ev_sq.sq = mag[30:0] * mag[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_take) begin
      q_valid <= p_move;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      q_ev <= p_ev_sq;
    end
  end

  // Statistics stage.
  assign sum_ext = {sum_of_delays[63], sum_of_delays} + {{33{q_ev.d[31]}}, q_ev.d};
  assign sq_ext  = {1'b0, sum_of_squares} + {2'd0, q_ev.sq};

  always_comb begin
    match_tally_next  = dcedm_pkg::sat_inc(match_tally, q_ev.matched);
    miss_tally_a_next = dcedm_pkg::sat_inc(miss_tally_a, q_ev.miss_a);
    miss_tally_b_next = dcedm_pkg::sat_inc(miss_tally_b, q_ev.miss_b);
    least_delay_next    = least_delay;
    greatest_delay_next = greatest_delay;
    if (q_ev.matched && (q_ev.d < least_delay)) least_delay_next = q_ev.d;
    if (q_ev.matched && (q_ev.d > greatest_delay)) greatest_delay_next = q_ev.d;
    if (sum_ext[64] != sum_ext[63]) begin
      sum_of_delays_next = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_of_delays_next = sum_ext[63:0];
    end
    sum_of_squares_next = sq_ext[63] ? dcedm_pkg::SQ_MAX : sq_ext[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tally    <= '0;
      miss_tally_a   <= '0;
      miss_tally_b   <= '0;
      least_delay    <= 32'sh7fffffff;
      greatest_delay <= 32'sh80000000;
      sum_of_delays  <= '0;
      sum_of_squares <= '0;
    end else if (q_move) begin
      if ((q_ev.kind == dcedm_pkg::KIND_STATS) && q_ev.clr) begin
        match_tally    <= '0;
        miss_tally_a   <= '0;
        miss_tally_b   <= '0;
        least_delay    <= 32'sh7fffffff;
        greatest_delay <= 32'sh80000000;
        sum_of_delays  <= '0;
        sum_of_squares <= '0;
      end else begin
        match_tally    <= match_tally_next;
        miss_tally_a   <= miss_tally_a_next;
        miss_tally_b   <= miss_tally_b_next;
        least_delay    <= least_delay_next;
        greatest_delay <= greatest_delay_next;
        sum_of_delays  <= sum_of_delays_next;
        sum_of_squares <= sum_of_squares_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= q_move;
    end
  end

  always_ff @(posedge clk) begin
    if (q_move) begin
      out_item.matched            <= q_ev.matched;
      out_item.pair_ts_a          <= q_ev.raw_a;
      out_item.pair_ts_b          <= q_ev.raw_b;
      out_item.pair_delay         <= q_ev.d;
      out_item.match_count        <= match_tally_next;
      out_item.missed_count_a     <= miss_tally_a_next;
      out_item.missed_count_b     <= miss_tally_b_next;
      out_item.delay_least        <= (match_tally_next != 32'd0) ? least_delay_next : 32'sd0;
      out_item.delay_greatest     <= (match_tally_next != 32'd0) ? greatest_delay_next : 32'sd0;
      out_item.delay_total        <= sum_of_delays_next;
      out_item.delay_square_total <= sum_of_squares_next;
    end
  end

endmodule

[rtl/dual_channel_edge_delay_matcher.sv]
// Top level of the dual channel edge delay matcher.
// Depends on dcedm_pkg, dcedm_front, dcedm_queue and dcedm_back.
//
// Usage: input beats on in_valid/in_ready/in_item carry edge captures, counter
// overflow events, timeout checks and statistics reads. Every input beat gives
// exactly one output beat on out_valid/out_ready/out_item, in order.
// Configuration writes arrive on cfg_valid/cfg_ready/cfg_index/cfg_data; index 0
// is the delay window, index 1 the maximum age. Write them only while idle.
// Throughput is one beat per cycle while the receiver does not stall. The item
// enters the queue at the edge that accepts the input beat, then passes the
// pairing stage and the squaring stage into the output register.
// When the receiver stalls the back-end stages fill, then the two-entry queue,
// after which in_ready falls; nothing is dropped.
// Reset clears pending edges, wrap counts and statistics, and loads the
// configuration registers with their defaults; the block is ready at once.
`timescale 1ns / 1ps

module dual_channel_edge_delay_matcher #(
  parameter int CAPTURE_WIDTH = dcedm_pkg::CAPTURE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcedm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcedm_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data
);

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  dcedm_pkg::wide_item_t push_item, pop_item;

  dcedm_front #(.CAPTURE_WIDTH(CAPTURE_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dcedm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dcedm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
